### src/itda_pkg.sv
`timescale 1ns / 1ps

package itda_pkg;

    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam int DIG_W      = $clog2(NUM_DIGITS);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic dig_last;
        logic neg;
        logic out_free;
    } status_t;

endpackage

### src/itda_datapath.sv
`timescale 1ns / 1ps

module itda_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          value,
    input  itda_pkg::cmd_t       cmd,
    output itda_pkg::status_t    status,
    output logic [7:0]           ascii_char,
    output logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall
);

    logic [itda_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic [itda_pkg::BCD_W-1:0]  bcd_reg, bcd_next;
    logic [itda_pkg::BCD_W-1:0]  bcd_adj;
    logic [itda_pkg::STEP_W-1:0] step_reg, step_next;
    logic [itda_pkg::DIG_W-1:0]  dig_left_reg, dig_left_next;
    logic                        neg_reg, neg_next;
    logic [7:0]                  char_reg, char_next;
    logic                        last_reg, last_next;
    logic                        out_valid_reg, out_valid_next;
    logic [3:0]                  top_digit;

    assign top_digit = bcd_reg[itda_pkg::BCD_W-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < itda_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        dig_left_next  = dig_left_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            neg_next      = value[31];
            mag_next      = value[31] ? (~value + 32'd1) : value;
            bcd_next      = '0;
            step_next     = '0;
            dig_left_next = itda_pkg::DIG_W'(itda_pkg::NUM_DIGITS - 1);
        end

        if (cmd.step)
        begin
            bcd_next  = {bcd_adj[itda_pkg::BCD_W-2:0], mag_reg[itda_pkg::MAG_W-1]};
            mag_next  = {mag_reg[itda_pkg::MAG_W-2:0], 1'b0};
            step_next = step_reg + itda_pkg::STEP_W'(1);
        end

        if (cmd.skip || cmd.emit_digit)
        begin
            bcd_next      = {bcd_reg[itda_pkg::BCD_W-5:0], 4'd0};
            dig_left_next = dig_left_reg - itda_pkg::DIG_W'(1);
        end

        if (cmd.emit_sign)
        begin
            char_next      = itda_pkg::CHAR_MINUS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end

        if (cmd.emit_digit)
        begin
            char_next      = itda_pkg::CHAR_ZERO + {4'd0, top_digit};
            last_next      = (dig_left_reg == '0);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        step_reg     <= step_next;
        dig_left_reg <= dig_left_next;
        neg_reg      <= neg_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    assign status.conv_done = (step_reg == itda_pkg::STEP_W'(itda_pkg::MAG_W - 1));
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.dig_last  = (dig_left_reg == '0);
    assign status.neg       = neg_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign out_valid  = out_valid_reg;

endmodule

### src/itda_ctrl.sv
`timescale 1ns / 1ps

module itda_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  itda_pkg::status_t status,
    output itda_pkg::cmd_t    cmd
);

    itda_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            itda_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = itda_pkg::ST_CONVERT;
                end
            end
            itda_pkg::ST_CONVERT:
            begin
                cmd.step = 1'b1;
                if (status.conv_done)
                begin
                    state_next = itda_pkg::ST_SKIP;
                end
            end
            itda_pkg::ST_SKIP:
            begin
                if (status.top_zero && !status.dig_last)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.neg)
                begin
                    state_next = itda_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = itda_pkg::ST_EMIT;
                end
            end
            itda_pkg::ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = itda_pkg::ST_EMIT;
                end
            end
            itda_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.dig_last)
                    begin
                        state_next = itda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = itda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps

// Converts a signed 32-bit integer into its decimal text, one ASCII character per
// output transfer, most significant character first.
// The input channel (value, in_valid, in_stall) takes one integer per transfer.
// The output channel (ascii_char, last, out_valid, out_stall) gives a '-' for a
// negative value and then the digits without leading zeros; last marks the final
// character. Zero gives the single character '0'.
// After an input transfer the magnitude goes through a 32-step shift-and-add-3
// binary-to-BCD conversion, one bit per cycle, then leading zero digits are
// dropped at one digit per cycle until the first digit is found, then one
// character is sent per cycle while the receiver does not stall.
// A new input is taken only after the last character of the current item has been
// placed in the output register, so it may be taken while that character waits.
// While out_stall is high the output register holds its character and the next
// character waits. Reset clears the controller and the output valid flag.
module int_to_decimal_ascii_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] value,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [7:0]  ascii_char,
    output logic        last,
    output logic        out_valid,
    input  logic        out_stall
);

    itda_pkg::cmd_t    cmd;
    itda_pkg::status_t status;

    itda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    itda_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .ascii_char (ascii_char),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a conversion was starting");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ascii_char == itda_pkg::CHAR_MINUS) ||
                      ((ascii_char >= itda_pkg::CHAR_ZERO) &&
                       (ascii_char <= itda_pkg::CHAR_NINE)))
        else $error("output character is neither a sign nor a digit");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ascii_char == itda_pkg::CHAR_MINUS) |-> !last)
        else $error("minus sign flagged as final character");
`endif

endmodule
